FILE: design/pqls_pkg.sv
// Shared constants, codes and types for the linear-scan priority queue.
`default_nettype none

package pqls_pkg;

	// Queue sizing
	localparam int QUEUE_DEPTH    = 16;
	localparam int PRIORITY_WIDTH = 8;

	localparam int IDX_W   = $clog2(QUEUE_DEPTH);
	localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
	localparam int VAL_W   = 32;
	localparam int ENTRY_W = VAL_W + PRIORITY_WIDTH;

	// Port field widths
	localparam int IN_PRIO_W = 8;
	localparam int STATUS_W  = 2;
	localparam int FILL_W    = 5;
	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 48;
	localparam int M_PAD_W   = M_TDATA_W - VAL_W - FILL_W;

	typedef enum logic {
		OP_ENQ = 1'b0,
		OP_DEQ = 1'b1
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_STORED   = 2'd0,
		STS_DEQUEUED = 2'd1,
		STS_EMPTY    = 2'd2,
		STS_FULL     = 2'd3
	} status_t;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_PICK  = 4'b0100,
		ST_SHIFT = 4'b1000
	} state_t;

	// Control for the shared compare unit
	typedef struct packed {
		logic valid;   // an entry is on the read bus this cycle
		logic first;   // it is the oldest entry: load unconditionally
	} scan_ctl_t;

endpackage

`default_nettype wire

FILE: design/pqls_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module pqls_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

FILE: design/pqls_scan_unit.sv
// Shared priority comparator that tracks the best entry seen during a scan.
`default_nettype none

module pqls_scan_unit
	import pqls_pkg::*;
(
	input  wire logic                      clk,
	input  wire scan_ctl_t                 ctl,
	input  wire logic [IDX_W-1:0]          idx,
	input  wire logic [PRIORITY_WIDTH-1:0] entry_prio,
	input  wire logic [VAL_W-1:0]          entry_value,
	output logic      [IDX_W-1:0]          best_idx,
	output logic      [VAL_W-1:0]          best_value
);

	logic [PRIORITY_WIDTH-1:0] best_prio_q;
	logic [IDX_W-1:0]          best_idx_q;
	logic [VAL_W-1:0]          best_value_q;
	logic                      take;

	// strictly greater only, so the oldest wins a tie
	assign take = ctl.valid && (ctl.first || (entry_prio > best_prio_q));

	always_ff @(posedge clk) begin
		if (take) begin
			best_prio_q  <= entry_prio;
			best_idx_q   <= idx;
			best_value_q <= entry_value;
		end
	end

	assign best_idx   = best_idx_q;
	assign best_value = best_value_q;

endmodule

`default_nettype wire

FILE: design/priority_queue_linear_scan.sv
// Top level: bounded priority queue over an unsorted store, scanned by one comparator.
//
//  channel | direction | tdata (low bit up)                  | tuser
//  s_*     | in        | item_value[31:0], item_priority[7:0] | opcode
//  m_*     | out       | out_value[31:0], fill_count[4:0]    | status[1:0]
//
// Enqueue, full enqueue and empty dequeue: the result is set pending on accept and
// moves to the output register, and so to m_tvalid, once that register is free.
// Dequeue: the scan reads each held entry in turn, the pick state takes the winner,
// then the shift state moves every entry behind the winner down one place to close
// the gap before the result is set pending. The single read port of the entry RAM
// and the one comparator make the scan sequential.
// arst_n clears the sequencer, the fill count and the output valid flag; the
// entry RAM and the result payload registers hold no reset value.
// A result held in the output register does not block the next accept.
`default_nettype none

module priority_queue_linear_scan
	import pqls_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [S_TDATA_W-1:0]  s_tdata,   // item_value, item_priority
	input  wire logic                  s_tuser,   // opcode
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic      [M_TDATA_W-1:0]  m_tdata,   // out_value, fill_count, zero pad
	output logic      [STATUS_W-1:0]   m_tuser    // status
);

	state_t                    state_q;
	logic [CNT_W-1:0]          count_q;
	logic [IDX_W-1:0]          ptr_q;
	logic [IDX_W-1:0]          cmp_idx_q;
	logic [IDX_W-1:0]          sh_q;
	logic                      res_pend_q;
	logic [VAL_W-1:0]          res_value_q;
	status_t                   res_status_q;
	logic                      out_valid_q;
	logic [VAL_W-1:0]          out_value_q;
	status_t                   out_status_q;
	logic [FILL_W-1:0]         out_fill_q;

	logic                      s_fire;
	logic                      out_load;
	opcode_t                   in_op;
	logic [VAL_W-1:0]          in_value;
	logic [PRIORITY_WIDTH-1:0] in_prio;
	logic                      is_full;
	logic                      is_empty;
	logic                      scan_last;
	logic                      shift_more;

	logic                      ram_we;
	logic [IDX_W-1:0]          ram_waddr;
	logic [ENTRY_W-1:0]        ram_wdata;
	logic [IDX_W-1:0]          ram_raddr;
	logic [ENTRY_W-1:0]        ram_rdata;

	scan_ctl_t                 scan_ctl;
	logic [IDX_W-1:0]          best_idx;
	logic [VAL_W-1:0]          best_value;

	// Input unpacking
	assign in_op    = opcode_t'(s_tuser);
	assign in_value = s_tdata[VAL_W-1:0];
	assign in_prio  = PRIORITY_WIDTH'(s_tdata[VAL_W +: IN_PRIO_W]);

	assign s_tready = (state_q == ST_IDLE) && !res_pend_q;
	assign s_fire   = s_tvalid && s_tready;
	assign is_full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign is_empty = (count_q == '0);

	assign scan_last  = (CNT_W'(cmp_idx_q) == count_q - CNT_W'(1));
	assign shift_more = ((CNT_W'(sh_q) + CNT_W'(1)) < count_q);

	// A pending result moves to the output register once it is free
	assign out_load = res_pend_q && (!out_valid_q || m_tready);

	// RAM ports
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = sh_q;
		ram_wdata = ram_rdata;
		ram_raddr = ptr_q;
		unique case (state_q)
			ST_IDLE: begin
				ram_raddr = '0;
				if (s_fire && in_op == OP_ENQ && !is_full) begin
					ram_we    = 1'b1;
					ram_waddr = IDX_W'(count_q);
					ram_wdata = {in_prio, in_value};
				end
			end
			ST_SCAN: begin
				ram_raddr = ptr_q;
			end
			ST_PICK: begin
				ram_raddr = best_idx + IDX_W'(1);
			end
			ST_SHIFT: begin
				ram_raddr = sh_q + IDX_W'(2);
				ram_we    = shift_more;
			end
			default: begin
				ram_raddr = ptr_q;
			end
		endcase
	end

	assign scan_ctl.valid = (state_q == ST_SCAN);
	assign scan_ctl.first = (cmp_idx_q == '0);

	pqls_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	pqls_scan_unit u_scan (
		.clk        (clk),
		.ctl        (scan_ctl),
		.idx        (cmp_idx_q),
		.entry_prio (ram_rdata[VAL_W +: PRIORITY_WIDTH]),
		.entry_value(ram_rdata[VAL_W-1:0]),
		.best_idx   (best_idx),
		.best_value (best_value)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			ptr_q      <= '0;
			cmp_idx_q  <= '0;
			sh_q       <= '0;
			res_pend_q <= 1'b0;
		end else begin
			if (out_load) begin
				res_pend_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_fire) begin
						if (in_op == OP_ENQ) begin
							res_pend_q <= 1'b1;
							if (!is_full) begin
								count_q <= count_q + CNT_W'(1);
							end
						end else if (is_empty) begin
							res_pend_q <= 1'b1;
						end else begin
							ptr_q     <= IDX_W'(1);
							cmp_idx_q <= '0;
							state_q   <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					ptr_q     <= ptr_q + IDX_W'(1);
					cmp_idx_q <= cmp_idx_q + IDX_W'(1);
					if (scan_last) begin
						state_q <= ST_PICK;
					end
				end
				ST_PICK: begin
					sh_q    <= best_idx;
					state_q <= ST_SHIFT;
				end
				ST_SHIFT: begin
					if (shift_more) begin
						sh_q <= sh_q + IDX_W'(1);
					end else begin
						count_q    <= count_q - CNT_W'(1);
						res_pend_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (s_fire) begin
			res_value_q <= '0;
			if (in_op == OP_ENQ) begin
				res_status_q <= is_full ? STS_FULL : STS_STORED;
			end else begin
				res_status_q <= is_empty ? STS_EMPTY : STS_DEQUEUED;
			end
		end else if (state_q == ST_PICK) begin
			res_value_q <= best_value;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_value_q  <= res_value_q;
			out_status_q <= res_status_q;
			out_fill_q   <= FILL_W'(count_q);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{M_PAD_W{1'b0}}, out_fill_q, out_value_q};
	assign m_tuser  = out_status_q;

	// Checks
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("entry count above queue depth");

	a_enq_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(s_fire && in_op == OP_ENQ && !is_full) |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("stored enqueue did not grow the count");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (CNT_W'(cmp_idx_q) < count_q))
		else $error("scan index past the held entries");

	a_pend_lands: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (out_valid_q && !res_pend_q))
		else $error("pending result not moved to output register");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHIFT && shift_more) |=> !s_tready)
		else $error("input accepted while compaction is running");

endmodule

`default_nettype wire

FILE: sim/tb_priority_queue_linear_scan.sv
// Testbench for the linear-scan priority queue: shadow-queue prediction, stream stalls, pressure.
`timescale 1ns / 100ps

module tb_priority_queue_linear_scan;
	import pqls_pkg::*;

	localparam int CYCLE_LIMIT  = 500000;
	localparam int DRAIN_CYCLES = 2 * QUEUE_DEPTH + 20;
	localparam int HOLD_CYCLES  = 300;
	localparam int SEGMENTS     = 30;
	localparam int SEG_ITEMS    = 30;
	localparam int REPORT_MAX   = 10;

	// One expected output transaction
	typedef struct packed {
		logic [VAL_W-1:0]  value;
		status_t           status;
		logic [FILL_W-1:0] fill;
	} result_t;

	// One directed stimulus row; want is used only when typed is set
	typedef struct packed {
		opcode_t            op;
		logic [VAL_W-1:0]   value;
		logic [IN_PRIO_W-1:0] prio;
		logic               typed;
		result_t            want;
	} directed_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;   // item_value, item_priority
	logic                 s_tuser;   // opcode
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;   // out_value, fill_count, zero pad
	logic [STATUS_W-1:0]  m_tuser;   // status

	// Shadow copy of the queue contents, oldest entry at index 0
	logic [VAL_W-1:0]          shadow_value [QUEUE_DEPTH];
	logic [PRIORITY_WIDTH-1:0] shadow_prio  [QUEUE_DEPTH];
	int                        shadow_fill;

	result_t pending_results [$];

	bit pace_on;
	int rx_hold_cycles;
	int cycle_count;
	int fault_count;
	int results_checked;
	int items_sent;
	int enq_count;
	int deq_count;
	int full_count;
	int empty_count;
	int peak_fill;
	int holds_done;

	// Directed rows: empty dequeue, value and priority extremes, fill to full with equal priorities
	directed_row_t directed_steps [25] = '{
		'{OP_DEQ, 32'h0000_0000, 8'h00, 1'b1, '{32'h0, STS_EMPTY,  5'd0}},
		'{OP_ENQ, 32'h8000_0000, 8'h00, 1'b1, '{32'h0, STS_STORED, 5'd1}},
		'{OP_ENQ, 32'h7FFF_FFFF, 8'hFF, 1'b1, '{32'h0, STS_STORED, 5'd2}},
		'{OP_DEQ, 32'hFFFF_FFFF, 8'hFF, 1'b0, '0},
		'{OP_DEQ, 32'h0000_0000, 8'h00, 1'b0, '0},
		'{OP_DEQ, 32'h1234_5678, 8'h81, 1'b1, '{32'h0, STS_EMPTY,  5'd0}},
		'{OP_ENQ, 32'h5A00_0001, 8'h5A, 1'b1, '{32'h0, STS_STORED, 5'd1}},
		'{OP_ENQ, 32'h5A00_0002, 8'h5A, 1'b1, '{32'h0, STS_STORED, 5'd2}},
		'{OP_ENQ, 32'h5A00_0003, 8'h5A, 1'b1, '{32'h0, STS_STORED, 5'd3}},
		'{OP_ENQ, 32'h5A00_0004, 8'h5A, 1'b1, '{32'h0, STS_STORED, 5'd4}},
		'{OP_ENQ, 32'h5A00_0005, 8'h5A, 1'b1, '{32'h0, STS_STORED, 5'd5}},
		'{OP_ENQ, 32'h5A00_0006, 8'h5A, 1'b1, '{32'h0, STS_STORED, 5'd6}},
		'{OP_ENQ, 32'h5A00_0007, 8'h5A, 1'b1, '{32'h0, STS_STORED, 5'd7}},
		'{OP_ENQ, 32'h5A00_0008, 8'h5A, 1'b1, '{32'h0, STS_STORED, 5'd8}},
		'{OP_ENQ, 32'h5A00_0009, 8'h5A, 1'b1, '{32'h0, STS_STORED, 5'd9}},
		'{OP_ENQ, 32'h5A00_000A, 8'h5A, 1'b1, '{32'h0, STS_STORED, 5'd10}},
		'{OP_ENQ, 32'h5A00_000B, 8'h5A, 1'b1, '{32'h0, STS_STORED, 5'd11}},
		'{OP_ENQ, 32'h5A00_000C, 8'h5A, 1'b1, '{32'h0, STS_STORED, 5'd12}},
		'{OP_ENQ, 32'h5A00_000D, 8'h5A, 1'b1, '{32'h0, STS_STORED, 5'd13}},
		'{OP_ENQ, 32'h5A00_000E, 8'h5A, 1'b1, '{32'h0, STS_STORED, 5'd14}},
		'{OP_ENQ, 32'h5A00_000F, 8'h5A, 1'b1, '{32'h0, STS_STORED, 5'd15}},
		'{OP_ENQ, 32'h5A00_0010, 8'h5A, 1'b1, '{32'h0, STS_STORED, 5'd16}},
		'{OP_ENQ, 32'hDEAD_BEEF, 8'hFF, 1'b1, '{32'h0, STS_FULL,   5'd16}},
		'{OP_DEQ, 32'h0000_0000, 8'h00, 1'b0, '0},
		'{OP_DEQ, 32'h0000_0000, 8'h00, 1'b0, '0}
	};

	priority_queue_linear_scan dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Apply one transaction to the shadow queue and return what the block should answer
	function automatic result_t shadow_apply(opcode_t op, logic [VAL_W-1:0] val,
			logic [IN_PRIO_W-1:0] prio);
		result_t                   res;
		int                        best;
		logic [PRIORITY_WIDTH-1:0] kept_prio;
		kept_prio = prio[PRIORITY_WIDTH-1:0];
		res.value = '0;
		if (op == OP_ENQ) begin
			enq_count++;
			if (shadow_fill >= QUEUE_DEPTH) begin
				res.status = STS_FULL;
				full_count++;
			end else begin
				shadow_value[shadow_fill] = val;
				shadow_prio[shadow_fill]  = kept_prio;
				shadow_fill++;
				res.status = STS_STORED;
			end
		end else begin
			deq_count++;
			if (shadow_fill == 0) begin
				res.status = STS_EMPTY;
				empty_count++;
			end else begin
				// strictly greater wins, so ties stay with the oldest entry
				best = 0;
				for (int k = 1; k < shadow_fill; k++) begin
					if (shadow_prio[k] > shadow_prio[best])
						best = k;
				end
				res.value = shadow_value[best];
				for (int k = best; k + 1 < shadow_fill; k++) begin
					shadow_value[k] = shadow_value[k + 1];
					shadow_prio[k]  = shadow_prio[k + 1];
				end
				shadow_fill--;
				res.status = STS_DEQUEUED;
			end
		end
		if (shadow_fill > peak_fill)
			peak_fill = shadow_fill;
		res.fill = shadow_fill[FILL_W-1:0];
		return res;
	endfunction

	// Offer one input transaction, entered and left at a falling edge
	task automatic offer_item(input opcode_t op, input logic [VAL_W-1:0] val,
			input logic [IN_PRIO_W-1:0] prio, input logic typed, input result_t typed_res);
		int      gap;
		result_t predicted;
		gap = pace_on ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser  = op;
		s_tdata  = {prio, val};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predicted = shadow_apply(op, val, prio);
		pending_results.push_back(typed ? typed_res : predicted);
		items_sent++;
		@(negedge clk);
	endtask

	function automatic void note_fault(string what);
		fault_count++;
		if (fault_count <= REPORT_MAX)
			$display("[%0t] mismatch: %s", $realtime, what);
	endfunction

	// Result checker
	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				note_fault($sformatf("unexpected result value=%h status=%0d fill=%0d",
					m_tdata[VAL_W-1:0], m_tuser, m_tdata[VAL_W +: FILL_W]));
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				if (m_tdata[VAL_W-1:0] !== want.value || m_tuser !== want.status ||
						m_tdata[VAL_W +: FILL_W] !== want.fill ||
						m_tdata[M_TDATA_W-1 -: M_PAD_W] !== '0) begin
					note_fault($sformatf(
						"exp value=%h status=%0d fill=%0d, got value=%h status=%0d fill=%0d pad=%h",
						want.value, want.status, want.fill, m_tdata[VAL_W-1:0], m_tuser,
						m_tdata[VAL_W +: FILL_W], m_tdata[M_TDATA_W-1 -: M_PAD_W]));
				end
			end
		end
	end

	// Receiver: random stall per result, plus a long hold-off on request
	initial begin
		int stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (rx_hold_cycles > 0) begin
				m_tready = 1'b0;
				repeat (rx_hold_cycles) @(negedge clk);
				rx_hold_cycles = 0;
				holds_done++;
			end
			stall = pace_on ? $urandom_range(0, 3) : 0;
			if (stall > 0) begin
				m_tready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready = 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			@(negedge clk);
		end
	end

	// Watchdog
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timeout after %0d cycles, %0d results still pending",
			cycle_count, pending_results.size());
		$display("CHECK FAILED");
		$finish;
	end

	// Stimulus
	initial begin
		int               enq_pct;
		int               prio_mode;
		int               seg_len;
		opcode_t          op;
		logic [VAL_W-1:0] val;
		logic [IN_PRIO_W-1:0] prio;

		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = OP_ENQ;
		pace_on  = 1'b1;
		rx_hold_cycles = 0;
		shadow_fill    = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed rows
		foreach (directed_steps[i])
			offer_item(directed_steps[i].op, directed_steps[i].value, directed_steps[i].prio,
				directed_steps[i].typed, directed_steps[i].want);

		// Random segments, each with its own enqueue bias and priority spread
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			seg_len = SEG_ITEMS;
			case ($urandom_range(0, 2))
				0:       enq_pct = 85;
				1:       enq_pct = 50;
				default: enq_pct = 15;
			endcase
			prio_mode = $urandom_range(0, 2);
			pace_on   = ($urandom_range(0, 3) != 0);

			// Long receiver hold-off while the sender keeps pushing
			if (seg == SEGMENTS / 4) begin
				enq_pct = 85;
				pace_on = 1'b0;
				seg_len = 40;
				rx_hold_cycles = HOLD_CYCLES;
			end
			// Sender pause until the block has answered everything
			if (seg == SEGMENTS / 2) begin
				s_tvalid = 1'b0;
				wait (pending_results.size() == 0);
				@(negedge clk);
			end

			for (int n = 0; n < seg_len; n++) begin
				op = ($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ;
				case ($urandom_range(0, 9))
					0:       val = 32'h8000_0000;
					1:       val = 32'h7FFF_FFFF;
					2:       val = '0;
					3:       val = '1;
					default: val = $urandom;
				endcase
				case (prio_mode)
					0:       prio = IN_PRIO_W'($urandom_range(0, 3));
					1:       prio = $urandom_range(0, 1) ? 8'hFF : 8'h00;
					default: prio = IN_PRIO_W'($urandom_range(0, 255));
				endcase
				offer_item(op, val, prio, 1'b0, '0);
			end
		end
		s_tvalid = 1'b0;

		// Drain
		wait (pending_results.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_results.size() != 0)
			note_fault($sformatf("%0d results never arrived", pending_results.size()));

		$display("Sent %0d transactions: %0d enqueue (%0d refused full), %0d dequeue (%0d empty)",
			items_sent, enq_count, full_count, deq_count, empty_count);
		$display("Checked %0d results, peak fill %0d, %0d long hold-offs, %0d mismatches",
			results_checked, peak_fill, holds_done, fault_count);
		if (fault_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

FILE: priority_queue_linear_scan.f
design/pqls_pkg.sv
design/pqls_ram.sv
design/pqls_scan_unit.sv
design/priority_queue_linear_scan.sv
sim/tb_priority_queue_linear_scan.sv
